@@ rtl/ssc_pkg.sv @@
`timescale 1ns / 1ps

package ssc_pkg;

  localparam int MAX_LEN_DEF = 16;
  localparam int MAX_LEN_TOP = 64;
  localparam int PTR_W       = $clog2(MAX_LEN_TOP + 1);
  localparam int CH_W        = 8;
  localparam int RES_W       = 5;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CH_W-1:0]  ch_t;

  typedef enum logic {
    OP_REF   = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic {
    S_RUN,
    S_DRAIN
  } state_t;

  typedef struct packed {
    logic clr;
    logic new_ref;
    logic ld;
    logic upd;
    ch_t  ch;
    ptr_t ptr;
  } cell_ctrl_t;

  typedef struct packed {
    ptr_t best;
    ptr_t cnt;
  } acc_t;

endpackage

@@ rtl/ssc_ifs.sv @@
`timescale 1ns / 1ps

interface ssc_in_if;
  import ssc_pkg::*;
  logic valid;
  logic ready;
  logic op;
  ch_t  ch;
  logic last;
  modport source (output valid, output op, output ch, output last, input ready);
  modport sink (input valid, input op, input ch, input last, output ready);
endinterface

interface ssc_out_if;
  import ssc_pkg::*;
  logic             valid;
  logic             ready;
  logic [RES_W-1:0] longest_common;
  logic [RES_W-1:0] positional_matches;
  logic             truncated;
  modport source (output valid, output longest_common, output positional_matches,
                  output truncated, input ready);
  modport sink (input valid, input longest_common, input positional_matches,
                input truncated, output ready);
endinterface

@@ rtl/ssc_cell.sv @@
`timescale 1ns / 1ps

module ssc_cell
  import ssc_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  ptr_t       run_in,
  output ptr_t       run_out,
  input  acc_t       acc_in,
  output acc_t       acc_out
);

  ch_t  ref_r;
  logic valid_r, valid_nxt;
  ptr_t run_r, run_nxt;
  ptr_t best_r, best_nxt;
  logic pm_r, pm_nxt;
  acc_t acc_r, acc_nxt;
  logic here;
  logic hit;

  assign here = (ctrl.ptr == PTR_W'(IDX));
  assign hit  = valid_r && (ref_r == ctrl.ch);

  always_comb begin
    valid_nxt = valid_r;
    if (ctrl.new_ref) begin
      valid_nxt = 1'b0;
    end
    if (ctrl.ld && here) begin
      valid_nxt = 1'b1;
    end
  end

  always_comb begin
    run_nxt  = run_r;
    best_nxt = best_r;
    pm_nxt   = pm_r;
    if (ctrl.clr) begin
      run_nxt  = '0;
      best_nxt = '0;
      pm_nxt   = 1'b0;
    end else if (ctrl.upd) begin
      run_nxt  = hit ? run_in + PTR_W'(1) : '0;
      best_nxt = (run_nxt > best_r) ? run_nxt : best_r;
      pm_nxt   = pm_r | (hit && here);
    end
  end

  always_comb begin
    acc_nxt.best = (acc_in.best > best_r) ? acc_in.best : best_r;
    acc_nxt.cnt  = acc_in.cnt + PTR_W'(pm_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      run_r   <= '0;
      best_r  <= '0;
      pm_r    <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      run_r   <= run_nxt;
      best_r  <= best_nxt;
      pm_r    <= pm_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld && here) begin
      ref_r <= ctrl.ch;
    end
    acc_r <= acc_nxt;
  end

  assign run_out = run_r;
  assign acc_out = acc_r;

endmodule

@@ rtl/string_similarity_scorer_top.sv @@
`timescale 1ns / 1ps

// Scores a query byte string against a stored reference string. Send the
// reference with op = 0 and last on its final byte, then the query with op = 1
// and last on its final byte; each query ends in one result holding the longest
// common contiguous run, the count of equal bytes at equal positions and a
// truncation flag, and the reference stays loaded for further queries. Each
// byte goes to a row of MAX_LEN cells, one per reference position, that
// update their diagonal runs together. After the last query byte the row
// folds its per-cell maxima and counts toward the far end, one cell per
// cycle, so the block stops taking bytes until the result lands in the
// output register. Bytes past MAX_LEN are dropped and flagged.
module string_similarity_scorer_top
  import ssc_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input logic      clk,
  input logic      rst_n,
  ssc_in_if.sink   in_if,
  ssc_out_if.source out_if
);

  state_t state_r, state_nxt;
  ptr_t   ref_len_r, ref_len_nxt;
  logic   ref_open_r, ref_open_nxt;
  logic   ref_cut_r, ref_cut_nxt;
  ptr_t   pos_r, pos_nxt;
  logic   qcut_r, qcut_nxt;
  ptr_t   cnt_r, cnt_nxt;

  logic   out_valid_r, out_valid_nxt;
  logic [RES_W-1:0] lc_r, pmc_r;
  logic   trunc_r;

  logic   take;
  logic   acc_ref;
  logic   acc_q;
  logic   finish;
  logic   pos_full;
  logic   len_full;
  cell_ctrl_t ctrl;

  ptr_t run_w [MAX_LEN+1];
  acc_t acc_w [MAX_LEN+1];

  assign acc_ref  = take && (op_t'(in_if.op) == OP_REF);
  assign acc_q    = take && (op_t'(in_if.op) == OP_QUERY);
  assign pos_full = (pos_r >= PTR_W'(MAX_LEN));
  assign len_full = (ref_len_r >= PTR_W'(MAX_LEN));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_RUN: begin
        if (acc_q && in_if.last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (finish) begin
          state_nxt = S_RUN;
        end
      end
      default: state_nxt = S_RUN;
    endcase
  end

  always_comb begin
    take   = 1'b0;
    finish = 1'b0;
    unique case (state_r)
      S_RUN: begin
        take = in_if.valid;
      end
      S_DRAIN: begin
        finish = (cnt_r == PTR_W'(MAX_LEN)) && (!out_valid_r || out_if.ready);
      end
      default: begin
        take   = 1'b0;
        finish = 1'b0;
      end
    endcase
  end

  assign in_if.ready = (state_r == S_RUN);

  always_comb begin
    ctrl.clr     = acc_ref || finish;
    ctrl.new_ref = acc_ref && !ref_open_r;
    ctrl.ld      = acc_ref && (!ref_open_r || !len_full);
    ctrl.upd     = acc_q && !pos_full;
    ctrl.ch      = in_if.ch;
    if (acc_q) begin
      ctrl.ptr = pos_r;
    end else if (!ref_open_r) begin
      ctrl.ptr = '0;
    end else begin
      ctrl.ptr = ref_len_r;
    end
  end

  always_comb begin
    ref_len_nxt  = ref_len_r;
    ref_open_nxt = ref_open_r;
    ref_cut_nxt  = ref_cut_r;
    pos_nxt      = pos_r;
    qcut_nxt     = qcut_r;
    cnt_nxt      = '0;
    if (state_r == S_DRAIN && cnt_r != PTR_W'(MAX_LEN)) begin
      cnt_nxt = cnt_r + PTR_W'(1);
    end else if (state_r == S_DRAIN && !finish) begin
      cnt_nxt = cnt_r;
    end
    if (acc_ref) begin
      pos_nxt      = '0;
      qcut_nxt     = 1'b0;
      ref_open_nxt = !in_if.last;
      if (!ref_open_r) begin
        ref_len_nxt = PTR_W'(1);
        ref_cut_nxt = 1'b0;
      end else if (!len_full) begin
        ref_len_nxt = ref_len_r + PTR_W'(1);
      end else begin
        ref_cut_nxt = 1'b1;
      end
    end
    if (acc_q) begin
      ref_open_nxt = 1'b0;
      if (pos_full) begin
        qcut_nxt = 1'b1;
      end else begin
        pos_nxt = pos_r + PTR_W'(1);
      end
    end
    if (finish) begin
      pos_nxt  = '0;
      qcut_nxt = 1'b0;
    end
  end

  assign out_valid_nxt = finish || (out_valid_r && !out_if.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RUN;
      ref_len_r   <= '0;
      ref_open_r  <= 1'b0;
      ref_cut_r   <= 1'b0;
      pos_r       <= '0;
      qcut_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ref_len_r   <= ref_len_nxt;
      ref_open_r  <= ref_open_nxt;
      ref_cut_r   <= ref_cut_nxt;
      pos_r       <= pos_nxt;
      qcut_r      <= qcut_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      lc_r    <= acc_w[MAX_LEN].best[RES_W-1:0];
      pmc_r   <= acc_w[MAX_LEN].cnt[RES_W-1:0];
      trunc_r <= qcut_r || ref_cut_r;
    end
  end

  assign run_w[0] = '0;
  assign acc_w[0] = '0;

  for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
    ssc_cell #(
      .IDX (k)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl),
      .run_in  (run_w[k]),
      .run_out (run_w[k+1]),
      .acc_in  (acc_w[k]),
      .acc_out (acc_w[k+1])
    );
  end

  assign out_if.valid              = out_valid_r;
  assign out_if.longest_common     = lc_r;
  assign out_if.positional_matches = pmc_r;
  assign out_if.truncated          = trunc_r;

endmodule
